// ----- rtl/lcar_pkg.sv -----
// shared constants, types and helpers for the load cell adc reader
`timescale 1ns / 1ps

package lcar_pkg;

    // data and timing widths
    localparam int DATA_BITS     = 24;
    localparam int TIMER_BITS    = 16;
    localparam int HALF_BITS     = 16;
    localparam int FACTOR_BITS   = 32;
    localparam int WEIGHT_BITS   = 32;
    localparam int FRAC_SHIFT    = 24;
    localparam int LEN_BITS      = TIMER_BITS + 1;
    localparam int PULSE_BITS    = $clog2(DATA_BITS + 2);
    localparam int DIV_BITS      = DATA_BITS + FRAC_SHIFT;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);

    // configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_PERIOD     = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNTS_PER_GRAM = CFG_IDX_BITS'(1);
    localparam logic [HALF_BITS-1:0]    HALF_RESET          = HALF_BITS'(1000);
    localparam logic [FACTOR_BITS-1:0]  FACTOR_RESET        = FACTOR_BITS'(65536);

    // top bit flip for offset binary
    localparam logic [DATA_BITS-1:0] RAW_FLIP = DATA_BITS'(1) << (DATA_BITS - 1);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};

    // serial clock phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    // divider sequencer
    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } t_back_state;

    // one classified tick handed from front to back
    typedef struct packed {
        logic                 sck;
        logic                 sample;
        logic [DATA_BITS-1:0] raw;
    } t_job;

    // phase length: zero counts as one, capped at the timer range
    function automatic logic [LEN_BITS-1:0] phase_len(input logic [HALF_BITS-1:0] hp);
        logic [32:0] ext;
        logic [32:0] cap;
        ext = 33'(hp);
        cap = 33'(1) << TIMER_BITS;
        if (ext == 33'd0) begin
            ext = 33'd1;
        end
        if (ext > cap) begin
            ext = cap;
        end
        return ext[LEN_BITS-1:0];
    endfunction

endpackage

// ----- rtl/lcar_ifs.sv -----
// handshake channel interfaces for ticks, results and configuration
`timescale 1ns / 1ps

interface lcar_in_if;
    logic valid;
    logic ready;
    logic dout_level;

    modport source (output valid, output dout_level, input ready);
    modport sink   (input valid, input dout_level, output ready);
endinterface

interface lcar_out_if;
    import lcar_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   sck_level;
    logic                   sample_valid;
    logic [DATA_BITS-1:0]   raw_code;
    logic [WEIGHT_BITS-1:0] weight_grams;
    logic                   weight_saturated;

    modport source (output valid, output sck_level, output sample_valid, output raw_code,
                    output weight_grams, output weight_saturated, input ready);
    modport sink   (input valid, input sck_level, input sample_valid, input raw_code,
                    input weight_grams, input weight_saturated, output ready);
endinterface

interface lcar_cfg_if;
    import lcar_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/lcar_front.sv -----
// front end: serial clock sequencer that classifies each tick into a job
`timescale 1ns / 1ps

module lcar_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick_valid,
    input  logic                          i_dout_level,
    input  logic [lcar_pkg::HALF_BITS-1:0] i_half_period,
    input  logic                          i_push_ready,
    output logic                          o_push_valid,
    output lcar_pkg::t_job                o_job
);
    import lcar_pkg::*;

    t_phase                r_phase,  n_phase;
    logic [PULSE_BITS-1:0] r_pulse,  n_pulse;
    logic [TIMER_BITS-1:0] r_timer,  n_timer;
    logic [DATA_BITS-1:0]  r_shift,  n_shift;

    logic                  accept;
    logic [LEN_BITS-1:0]   len;
    logic [LEN_BITS-1:0]   timer_inc;
    logic                  phase_end;
    logic [PULSE_BITS-1:0] pulse_inc;

    assign accept       = i_tick_valid && i_push_ready;
    assign o_push_valid = i_tick_valid;
    assign len          = phase_len(i_half_period);
    assign timer_inc    = LEN_BITS'(r_timer) + LEN_BITS'(1);
    assign phase_end    = timer_inc >= len;
    assign pulse_inc    = r_pulse + PULSE_BITS'(1);

    // next phase, counters and job for this tick
    always_comb begin
        n_phase      = r_phase;
        n_pulse      = r_pulse;
        n_timer      = r_timer;
        n_shift      = r_shift;
        o_job.sck    = 1'b0;
        o_job.sample = 1'b0;
        o_job.raw    = r_shift ^ RAW_FLIP;
        unique case (r_phase)
            PH_HIGH: begin
                o_job.sck = 1'b1;
                if (phase_end) begin
                    if (r_pulse < PULSE_BITS'(DATA_BITS)) begin
                        n_shift = {r_shift[DATA_BITS-2:0], i_dout_level};
                    end
                    n_phase   = PH_LOW;
                    n_timer   = '0;
                    o_job.sck = 1'b0;
                end else begin
                    n_timer = timer_inc[TIMER_BITS-1:0];
                end
            end
            PH_LOW: begin
                if (phase_end) begin
                    n_timer = '0;
                    if (pulse_inc >= PULSE_BITS'(DATA_BITS + 1)) begin
                        o_job.sample = 1'b1;
                        n_phase      = PH_IDLE;
                        n_pulse      = '0;
                    end else begin
                        n_pulse   = pulse_inc;
                        n_phase   = PH_HIGH;
                        o_job.sck = 1'b1;
                    end
                end else begin
                    n_timer = timer_inc[TIMER_BITS-1:0];
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (!i_dout_level) begin
                    n_phase   = PH_HIGH;
                    n_pulse   = '0;
                    n_timer   = '0;
                    n_shift   = '0;
                    o_job.sck = 1'b1;
                end
            end
        endcase
    end

    // state registers advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pulse <= '0;
            r_timer <= '0;
            r_shift <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pulse <= n_pulse;
            r_timer <= n_timer;
            r_shift <= n_shift;
        end
    end

endmodule

// ----- rtl/lcar_queue.sv -----
// two-entry job queue between the front end and the divider back end
`timescale 1ns / 1ps

module lcar_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  lcar_pkg::t_job i_push_job,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output lcar_pkg::t_job o_pop_job,
    input  logic           i_pop
);
    import lcar_pkg::*;

    t_job        r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;

    assign o_push_ready = r_count != 2'd2;
    assign o_pop_valid  = r_count != 2'd0;
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/lcar_back.sv -----
// back end: restoring divider for the weight and the result word register
`timescale 1ns / 1ps

module lcar_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    input  lcar_pkg::t_job                   i_job,
    output logic                             o_job_pop,
    input  logic [lcar_pkg::FACTOR_BITS-1:0] i_counts_per_gram,
    lcar_out_if.source                       o_out
);
    import lcar_pkg::*;

    t_back_state             r_state;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [FACTOR_BITS-1:0]  r_rem;
    logic [DIV_BITS-1:0]     r_quo;
    logic [DATA_BITS-1:0]    r_job_raw;
    logic [DATA_BITS-1:0]    r_last_raw;
    logic [WEIGHT_BITS-1:0]  r_last_weight;

    logic                    r_out_valid;
    logic                    r_out_sck;
    logic                    r_out_sample;
    logic [DATA_BITS-1:0]    r_out_raw;
    logic [WEIGHT_BITS-1:0]  r_out_weight;
    logic                    r_out_sat;

    logic                    slot_free;
    logic                    pass_job;
    logic                    start_div;
    logic                    emit_div;
    logic [FACTOR_BITS:0]    cand;
    logic                    ge;
    logic                    div_sat;
    logic [WEIGHT_BITS-1:0]  div_weight;

    assign slot_free = !r_out_valid || o_out.ready;
    assign pass_job  = (r_state == BK_IDLE) && i_job_valid && !i_job.sample && slot_free;
    assign start_div = (r_state == BK_IDLE) && i_job_valid && i_job.sample;
    assign emit_div  = (r_state == BK_DONE) && slot_free;
    assign o_job_pop = pass_job || start_div;

    // one quotient bit per cycle; a zero factor yields all ones and saturates
    assign cand       = {r_rem, r_quo[DIV_BITS-1]};
    assign ge         = cand >= {1'b0, i_counts_per_gram};
    assign div_sat    = r_quo > DIV_BITS'(WEIGHT_MAX);
    assign div_weight = div_sat ? WEIGHT_MAX : r_quo[WEIGHT_BITS-1:0];

    // divider sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                BK_IDLE: begin
                    if (start_div) begin
                        r_state <= BK_DIV;
                        r_cnt   <= '0;
                    end
                end
                BK_DIV: begin
                    r_cnt <= r_cnt + DIV_CNT_BITS'(1);
                    if (r_cnt == DIV_CNT_BITS'(DIV_BITS - 1)) begin
                        r_state <= BK_DONE;
                    end
                end
                BK_DONE: begin
                    if (emit_div) begin
                        r_state <= BK_IDLE;
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_rem     <= '0;
            r_quo     <= {i_job.raw, {FRAC_SHIFT{1'b0}}};
            r_job_raw <= i_job.raw;
        end else if (r_state == BK_DIV) begin
            r_rem <= ge ? FACTOR_BITS'(cand - {1'b0, i_counts_per_gram})
                        : cand[FACTOR_BITS-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], ge};
        end
    end

    // last completed sample, held between samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= '0;
            r_last_weight <= '0;
        end else if (emit_div) begin
            r_last_raw    <= r_job_raw;
            r_last_weight <= div_weight;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pass_job || emit_div) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pass_job) begin
            r_out_sck    <= i_job.sck;
            r_out_sample <= 1'b0;
            r_out_raw    <= r_last_raw;
            r_out_weight <= r_last_weight;
            r_out_sat    <= 1'b0;
        end else if (emit_div) begin
            r_out_sck    <= 1'b0;
            r_out_sample <= 1'b1;
            r_out_raw    <= r_job_raw;
            r_out_weight <= div_weight;
            r_out_sat    <= div_sat;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.sck_level        = r_out_sck;
    assign o_out.sample_valid     = r_out_sample;
    assign o_out.raw_code         = r_out_raw;
    assign o_out.weight_grams     = r_out_weight;
    assign o_out.weight_saturated = r_out_sat;

endmodule

// ----- rtl/load_cell_adc_reader_top.sv -----
// load cell adc reader top level: config registers, front end, job queue, divider back end
// path: a plain tick's word passes through the job queue and the result word register;
// the tick that ends the 25th pulse gives its word once the 48-step bit-serial divider has run
// throughput: one tick per cycle while the job queue has room; a sample tick holds the back end
// while the divider runs, and later ticks wait in the two-entry queue
// reset: synchronous active low, config returns to 1000 ticks and factor 1.0, serial idle
`timescale 1ns / 1ps

module load_cell_adc_reader_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcar_in_if.sink    i_in,
    lcar_out_if.source o_out,
    lcar_cfg_if.sink   i_cfg
);
    import lcar_pkg::*;

    logic [HALF_BITS-1:0]   r_half_period;
    logic [FACTOR_BITS-1:0] r_counts_per_gram;

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    t_job pop_job;
    logic pop;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period     <= HALF_RESET;
            r_counts_per_gram <= FACTOR_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_HALF_PERIOD:     r_half_period     <= i_cfg.data[HALF_BITS-1:0];
                REG_COUNTS_PER_GRAM: r_counts_per_gram <= i_cfg.data[FACTOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // tick handshake follows queue room
    assign i_in.ready = push_ready;

    lcar_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_valid  (i_in.valid),
        .i_dout_level  (i_in.dout_level),
        .i_half_period (r_half_period),
        .i_push_ready  (push_ready),
        .o_push_valid  (push_valid),
        .o_job         (push_job)
    );

    lcar_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop        (pop)
    );

    lcar_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (pop_valid),
        .i_job             (pop_job),
        .o_job_pop         (pop),
        .i_counts_per_gram (r_counts_per_gram),
        .o_out             (o_out)
    );

    // a finished sample always leaves the serial clock low
    a_sample_sck_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.sample_valid |-> !o_out.sck_level)
        else $error("sample word with serial clock high");

    // saturation only on a sample word, with the weight pinned at full scale
    a_sat_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.weight_saturated |->
            o_out.sample_valid && (o_out.weight_grams == WEIGHT_MAX))
        else $error("saturation flag without full scale sample");

    // a half period write lands in its register
    a_half_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && (i_cfg.index == REG_HALF_PERIOD) |=>
            r_half_period == $past(i_cfg.data[HALF_BITS-1:0]))
        else $error("half period write lost");

    // ticks are refused only while the queue is full; checked here as a non-empty queue
    a_ready_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> pop_valid)
        else $error("tick refused with empty queue");

endmodule
